/* rtl/core/pal_pkg.sv */
package pal_pkg;

    localparam int DEPTH_DEF       = 64;
    localparam int VALUE_WIDTH_DEF = 32;

    localparam int FUNC_W     = 2;
    localparam int IN_VALUE_W = 32;
    localparam int POS_W      = 7;
    localparam int STATUS_W   = 2;
    localparam int FOUND_W    = 6;
    localparam int LENGTH_W   = 7;

    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 16;

    localparam logic [FUNC_W-1:0] FUNC_FIND   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BADPOS   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

    typedef enum logic [1:0] {
        CMD_HOLD,
        CMD_INS,
        CMD_DEL,
        CMD_FIND
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t op;
        logic    valid;
    } cell_cmd_t;

endpackage

/* rtl/core/pal_cell.sv */
module pal_cell #(
    parameter int IDX         = 0,
    parameter int VALUE_WIDTH = pal_pkg::VALUE_WIDTH_DEF,
    parameter int IW          = 6,
    parameter int CW          = 7
) (
    input  logic                   aclk,
    input  pal_pkg::cell_cmd_t     cmd,
    input  logic [IW-1:0]          slot,
    input  logic [CW-1:0]          count,
    input  logic [VALUE_WIDTH-1:0] value,
    input  logic [VALUE_WIDTH-1:0] left_data,
    input  logic [VALUE_WIDTH-1:0] right_data,
    output logic [VALUE_WIDTH-1:0] data,
    output logic                   match
);

    logic [VALUE_WIDTH-1:0] data_reg;
    logic                   match_reg;

    always_ff @(posedge aclk) begin
        if (cmd.valid) begin
            case (cmd.op)
                pal_pkg::CMD_INS: begin
                    if (slot == IW'(IDX)) begin
                        data_reg <= value;
                    end else if (slot < IW'(IDX)) begin
                        data_reg <= left_data;
                    end
                end
                pal_pkg::CMD_DEL: begin
                    if (slot <= IW'(IDX)) begin
                        data_reg <= right_data;
                    end
                end
                pal_pkg::CMD_FIND: begin
                    match_reg <= (CW'(IDX) < count) && (data_reg == value);
                end
                default: begin
                end
            endcase
        end
    end

    assign data  = data_reg;
    assign match = match_reg;

endmodule

/* rtl/core/positional_array_list.sv */
// Bounded ordered list of up to DEPTH values held in a row of cells, one entry
// per cell. Each input beat carries one operation: find (lowest index holding
// the value), insert at a 1-based position, or delete at a 1-based position;
// each yields exactly one result beat with status, found index and new length.
// One item is in flight at a time. The accepting edge captures the beat; in the
// execute state every cell shifts or compares in parallel, and the result state
// then priority-encodes the match bits into the output register, so a result
// is presented from that register. The next item is accepted while a
// result still waits in the output register, but it holds in the result stage
// until that register is free.
module positional_array_list #(
    parameter int DEPTH       = pal_pkg::DEPTH_DEF,
    parameter int VALUE_WIDTH = pal_pkg::VALUE_WIDTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // func[1:0], value[33:2], position[40:34], zero fill
    input  logic [pal_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // status[1:0], found_index[7:2], length[14:8], zero fill
    output logic [pal_pkg::M_TDATA_W-1:0]  m_tdata
);

    localparam int IW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = ((CW > pal_pkg::POS_W) ? CW : pal_pkg::POS_W) + 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_RESULT
    } state_t;

    state_t                          state_reg;
    logic [pal_pkg::FUNC_W-1:0]      func_reg;
    logic [VALUE_WIDTH-1:0]          value_reg;
    logic [pal_pkg::POS_W-1:0]       pos_reg;
    logic [CW-1:0]                   count_reg;
    logic [pal_pkg::STATUS_W-1:0]    status_reg;
    logic                            m_tvalid_reg;
    logic [pal_pkg::STATUS_W-1:0]    out_status_reg;
    logic [pal_pkg::FOUND_W-1:0]     out_found_reg;
    logic [pal_pkg::LENGTH_W-1:0]    out_length_reg;

    logic [pal_pkg::FUNC_W-1:0]      in_func;
    logic [pal_pkg::IN_VALUE_W-1:0]  in_value;
    logic [pal_pkg::POS_W-1:0]       in_pos;
    logic [VALUE_WIDTH-1:0]          in_value_w;

    pal_pkg::cell_cmd_t              cmd;
    logic [IW-1:0]                   slot;
    logic [CW-1:0]                   count_next;
    logic [pal_pkg::STATUS_W-1:0]    status_next;
    logic [CMPW-1:0]                 pos_w;
    logic [CMPW-1:0]                 cnt_w;

    logic [VALUE_WIDTH-1:0]          cell_data [DEPTH];
    logic [DEPTH-1:0]                match_vec;
    logic                            hit;
    logic [IW-1:0]                   hit_idx;
    logic                            out_load;
    logic [pal_pkg::STATUS_W-1:0]    out_status_next;
    logic [pal_pkg::FOUND_W-1:0]     out_found_next;

    assign in_func  = s_tdata[1:0];
    assign in_value = s_tdata[33:2];
    assign in_pos   = s_tdata[40:34];

    generate
        if (VALUE_WIDTH <= pal_pkg::IN_VALUE_W) begin : g_val_trunc
            assign in_value_w = in_value[VALUE_WIDTH-1:0];
        end else begin : g_val_ext
            assign in_value_w = {{(VALUE_WIDTH - pal_pkg::IN_VALUE_W){1'b0}}, in_value};
        end
    endgenerate

    assign s_tready = (state_reg == S_IDLE);
    assign out_load = (state_reg == S_RESULT) && (!m_tvalid_reg || m_tready);

    always_comb begin
        pos_w       = CMPW'(pos_reg);
        cnt_w       = CMPW'(count_reg);
        slot        = IW'(pos_w - CMPW'(1));
        cmd.valid   = (state_reg == S_EXEC);
        cmd.op      = pal_pkg::CMD_HOLD;
        count_next  = count_reg;
        status_next = pal_pkg::ST_OK;
        case (func_reg)
            pal_pkg::FUNC_FIND: begin
                cmd.op = pal_pkg::CMD_FIND;
            end
            pal_pkg::FUNC_INSERT: begin
                if (count_reg == CW'(DEPTH)) begin
                    status_next = pal_pkg::ST_FULL;
                end else if (pos_w == '0 || pos_w > cnt_w + CMPW'(1)) begin
                    status_next = pal_pkg::ST_BADPOS;
                end else begin
                    cmd.op     = pal_pkg::CMD_INS;
                    count_next = count_reg + CW'(1);
                end
            end
            pal_pkg::FUNC_DELETE: begin
                if (pos_w == '0 || pos_w > cnt_w) begin
                    status_next = pal_pkg::ST_BADPOS;
                end else begin
                    cmd.op     = pal_pkg::CMD_DEL;
                    count_next = count_reg - CW'(1);
                end
            end
            default: begin
            end
        endcase
    end

    generate
        for (genvar k = 0; k < DEPTH; k++) begin : g_cell
            logic [VALUE_WIDTH-1:0] left_d;
            logic [VALUE_WIDTH-1:0] right_d;
            if (k == 0) begin : g_first
                assign left_d = cell_data[k];
            end else begin : g_mid_l
                assign left_d = cell_data[k-1];
            end
            if (k == DEPTH - 1) begin : g_last
                assign right_d = cell_data[k];
            end else begin : g_mid_r
                assign right_d = cell_data[k+1];
            end
            pal_cell #(
                .IDX         (k),
                .VALUE_WIDTH (VALUE_WIDTH),
                .IW          (IW),
                .CW          (CW)
            ) u_cell (
                .aclk       (aclk),
                .cmd        (cmd),
                .slot       (slot),
                .count      (count_reg),
                .value      (value_reg),
                .left_data  (left_d),
                .right_data (right_d),
                .data       (cell_data[k]),
                .match      (match_vec[k])
            );
        end
    endgenerate

    always_comb begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int k = DEPTH - 1; k >= 0; k--) begin
            if (match_vec[k]) begin
                hit     = 1'b1;
                hit_idx = IW'(k);
            end
        end
    end

    always_comb begin
        out_status_next = status_reg;
        out_found_next  = '0;
        if (func_reg == pal_pkg::FUNC_FIND) begin
            if (hit) begin
                out_found_next = pal_pkg::FOUND_W'(hit_idx);
            end else begin
                out_status_next = pal_pkg::ST_NOTFOUND;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        func_reg  <= in_func;
                        value_reg <= in_value_w;
                        pos_reg   <= in_pos;
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    count_reg  <= count_next;
                    status_reg <= status_next;
                    state_reg  <= S_RESULT;
                end
                S_RESULT: begin
                    if (out_load) begin
                        out_length_reg <= pal_pkg::LENGTH_W'(count_reg);
                        out_found_reg  <= out_found_next;
                        out_status_reg <= out_status_next;
                        state_reg      <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, out_length_reg, out_found_reg, out_status_reg};

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("list length above depth");

    a_accept_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == S_EXEC))
        else $error("accepted beat not executed");

    a_full_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[1:0] == pal_pkg::ST_FULL)
            |-> (m_tdata[14:8] == pal_pkg::LENGTH_W'(DEPTH)))
        else $error("full status with short list");

    a_found_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[1:0] != pal_pkg::ST_OK) |-> (m_tdata[7:2] == '0))
        else $error("found index set on failed operation");

endmodule
